// ===== hw/rtl/jsu_pkg.sv =====
// Package for the JSON string unescaper: parser modes, result kinds, error codes,
// the queue entry type, and the UTF-8 encoding helper.
// No dependencies; every other file of the block imports it.
`default_nettype none

package jsu_pkg;

	// Parser modes of the front end. Any other encoding acts as idle.
	typedef enum logic [3:0] {
		MODE_IDLE    = 4'd0,
		MODE_BODY    = 4'd1,
		MODE_ESC     = 4'd2,
		MODE_HEX_A   = 4'd3,
		MODE_WANT_BS = 4'd4,
		MODE_WANT_U  = 4'd5,
		MODE_HEX_B   = 4'd6
	} mode_t;

	// Result kinds.
	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	// Error codes.
	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_NO_QUOTE = 3'd1;
	localparam logic [2:0] ERR_EARLY    = 3'd2;
	localparam logic [2:0] ERR_ESCAPE   = 3'd3;
	localparam logic [2:0] ERR_HEX      = 3'd4;
	localparam logic [2:0] ERR_NO_U     = 3'd5;
	localparam logic [2:0] ERR_LOW_SURR = 3'd6;
	localparam logic [2:0] ERR_CONTROL  = 3'd7;

	// Queue between front and back end.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// One queue entry: all results caused by one input byte.
	typedef struct packed {
		logic [1:0]      last_idx;  // number of results minus one
		logic [1:0]      kind;
		logic [2:0]      code;
		logic [3:0][7:0] bytes;     // data bytes in emission order, entry 0 first
	} job_t;

	// Encodes a code point of up to 21 bits into a data entry of 1 to 4 bytes.
	function automatic job_t utf8_job(input logic [20:0] cp);
		job_t j;
		j.kind  = KIND_DATA;
		j.code  = ERR_NONE;
		j.bytes = '0;
		if (cp[20:7] == '0) begin
			j.last_idx = 2'd0;
			j.bytes[0] = cp[7:0];
		end else if (cp[20:11] == '0) begin
			j.last_idx = 2'd1;
			j.bytes[0] = {3'b110, cp[10:6]};
			j.bytes[1] = {2'b10, cp[5:0]};
		end else if (cp[20:16] == '0) begin
			j.last_idx = 2'd2;
			j.bytes[0] = {4'b1110, cp[15:12]};
			j.bytes[1] = {2'b10, cp[11:6]};
			j.bytes[2] = {2'b10, cp[5:0]};
		end else begin
			j.last_idx = 2'd3;
			j.bytes[0] = {5'b11110, cp[20:18]};
			j.bytes[1] = {2'b10, cp[17:12]};
			j.bytes[2] = {2'b10, cp[11:6]};
			j.bytes[3] = {2'b10, cp[5:0]};
		end
		return j;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/jsu_front.sv =====
// Front end of the JSON string unescaper: parser state machine that classifies
// each input byte and builds the queue entry of its results. Uses jsu_pkg.
`default_nettype none

module jsu_front import jsu_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       fire,      // an input byte transfers this cycle
	input  wire logic [7:0] in_byte,
	input  wire logic       in_ended,
	output logic            push,      // entry goes into the queue
	output job_t            job
);

	mode_t       mode_q, mode_d;
	logic [1:0]  cnt_q, cnt_d;
	logic [15:0] acc_q, acc_d;
	logic [9:0]  hi_q, hi_d;

	logic        hex_ok;
	logic [3:0]  hex_dig;
	logic [15:0] acc_sh;
	logic        hex_done;
	logic        is_high;
	logic        is_low;
	logic [20:0] pair_cp;
	logic        has_res;

	function automatic job_t err_job(input logic [2:0] code);
		job_t j;
		j.last_idx = 2'd0;
		j.kind     = KIND_ERR;
		j.code     = code;
		j.bytes    = '0;
		return j;
	endfunction

	function automatic job_t byte_job(input logic [7:0] b);
		job_t j;
		j.last_idx = 2'd0;
		j.kind     = KIND_DATA;
		j.code     = ERR_NONE;
		j.bytes    = '0;
		j.bytes[0] = b;
		return j;
	endfunction

	// Hex digit decode and surrogate classification of the completed escape.
	always_comb begin
		hex_ok  = 1'b1;
		hex_dig = 4'd0;
		if (in_byte >= "0" && in_byte <= "9") begin
			hex_dig = 4'(in_byte - 8'h30);
		end else if (in_byte >= "a" && in_byte <= "f") begin
			hex_dig = 4'(in_byte - 8'h57);
		end else if (in_byte >= "A" && in_byte <= "F") begin
			hex_dig = 4'(in_byte - 8'h37);
		end else begin
			hex_ok = 1'b0;
		end
	end

	assign acc_sh   = {acc_q[11:0], hex_dig};
	assign hex_done = (cnt_q == 2'd3);
	assign is_high  = (acc_sh[15:10] == 6'b110110);
	assign is_low   = (acc_sh[15:10] == 6'b110111);
	// 0x10000 plus the two ten-bit halves: only the top bits need an add.
	assign pair_cp  = {({1'b0, hi_q[9:6]} + 5'd1), hi_q[5:0], acc_sh[9:0]};

	// Next-state logic of the parser.
	always_comb begin
		mode_d = mode_q;
		cnt_d  = cnt_q;
		acc_d  = acc_q;
		hi_d   = hi_q;
		if (in_ended) begin
			mode_d = MODE_IDLE;
			case (mode_q)
				MODE_BODY, MODE_ESC, MODE_HEX_A, MODE_WANT_BS, MODE_WANT_U, MODE_HEX_B: begin
					cnt_d = 2'd0;
					acc_d = 16'd0;
				end
				default: ;
			endcase
		end else begin
			case (mode_q)
				MODE_BODY: begin
					if (in_byte == "\"") begin
						mode_d = MODE_IDLE;
					end else if (in_byte == "\\") begin
						mode_d = MODE_ESC;
					end else if (in_byte < 8'h20) begin
						mode_d = MODE_IDLE;
						cnt_d  = 2'd0;
						acc_d  = 16'd0;
					end
				end
				MODE_ESC: begin
					case (in_byte)
						"\"", "\\", "/", "b", "f", "n", "r", "t": mode_d = MODE_BODY;
						"u": begin
							mode_d = MODE_HEX_A;
							cnt_d  = 2'd0;
							acc_d  = 16'd0;
						end
						default: begin
							mode_d = MODE_IDLE;
							cnt_d  = 2'd0;
							acc_d  = 16'd0;
						end
					endcase
				end
				MODE_HEX_A, MODE_HEX_B: begin
					if (!hex_ok) begin
						mode_d = MODE_IDLE;
						cnt_d  = 2'd0;
						acc_d  = 16'd0;
					end else if (!hex_done) begin
						cnt_d = cnt_q + 2'd1;
						acc_d = acc_sh;
					end else begin
						cnt_d = 2'd0;
						acc_d = 16'd0;
						if (mode_q == MODE_HEX_A) begin
							if (is_high) begin
								hi_d   = acc_sh[9:0];
								mode_d = MODE_WANT_BS;
							end else begin
								mode_d = MODE_BODY;
							end
						end else if (is_low) begin
							mode_d = MODE_BODY;
						end else begin
							mode_d = MODE_IDLE;
						end
					end
				end
				MODE_WANT_BS: begin
					if (in_byte == "\\") begin
						mode_d = MODE_WANT_U;
					end else begin
						mode_d = MODE_IDLE;
						cnt_d  = 2'd0;
						acc_d  = 16'd0;
					end
				end
				MODE_WANT_U: begin
					mode_d = MODE_IDLE;
					cnt_d  = 2'd0;
					acc_d  = 16'd0;
					if (in_byte == "u") begin
						mode_d = MODE_HEX_B;
					end
				end
				default: begin
					if (in_byte == "\"") begin
						mode_d = MODE_BODY;
					end else begin
						mode_d = MODE_IDLE;
						cnt_d  = 2'd0;
						acc_d  = 16'd0;
					end
				end
			endcase
		end
	end

	// Output logic: the results this byte causes, packed as one entry.
	always_comb begin
		has_res = 1'b0;
		job     = byte_job(8'd0);
		if (in_ended) begin
			case (mode_q)
				MODE_BODY, MODE_ESC, MODE_HEX_A, MODE_WANT_BS, MODE_WANT_U, MODE_HEX_B: begin
					has_res = 1'b1;
					job     = err_job(ERR_EARLY);
				end
				default: ;
			endcase
		end else begin
			case (mode_q)
				MODE_BODY: begin
					if (in_byte == "\"") begin
						has_res      = 1'b1;
						job.kind     = KIND_END;
					end else if (in_byte == "\\") begin
						has_res = 1'b0;
					end else if (in_byte < 8'h20) begin
						has_res = 1'b1;
						job     = err_job(ERR_CONTROL);
					end else begin
						has_res = 1'b1;
						job     = byte_job(in_byte);
					end
				end
				MODE_ESC: begin
					has_res = 1'b1;
					case (in_byte)
						"\"", "\\", "/": job = byte_job(in_byte);
						"b":             job = byte_job(8'h08);
						"f":             job = byte_job(8'h0C);
						"n":             job = byte_job(8'h0A);
						"r":             job = byte_job(8'h0D);
						"t":             job = byte_job(8'h09);
						"u":             has_res = 1'b0;
						default:         job = err_job(ERR_ESCAPE);
					endcase
				end
				MODE_HEX_A, MODE_HEX_B: begin
					if (!hex_ok) begin
						has_res = 1'b1;
						job     = err_job(ERR_HEX);
					end else if (hex_done) begin
						if (mode_q == MODE_HEX_A) begin
							has_res = !is_high;
							job     = utf8_job({5'd0, acc_sh});
						end else if (is_low) begin
							has_res = 1'b1;
							job     = utf8_job(pair_cp);
						end else begin
							has_res = 1'b1;
							job     = err_job(ERR_LOW_SURR);
						end
					end
				end
				MODE_WANT_BS: begin
					has_res = (in_byte != "\\");
					job     = err_job(ERR_NO_U);
				end
				MODE_WANT_U: begin
					has_res = (in_byte != "u");
					job     = err_job(ERR_NO_U);
				end
				default: begin
					has_res = (in_byte != "\"");
					job     = err_job(ERR_NO_QUOTE);
				end
			endcase
		end
	end

	assign push = fire && has_res;

	// Parser state registers, updated on each input transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			cnt_q  <= 2'd0;
			acc_q  <= 16'd0;
			hi_q   <= 10'd0;
		end else if (fire) begin
			mode_q <= mode_d;
			cnt_q  <= cnt_d;
			acc_q  <= acc_d;
			hi_q   <= hi_d;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/jsu_fifo.sv =====
// Short queue of result entries between the front and back ends of the
// JSON string unescaper. Uses jsu_pkg for the entry type and depth.
`default_nettype none

module jsu_fifo import jsu_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t wr_data,
	input  wire logic pop,
	output job_t      rd_data,
	output logic      full,
	output logic      empty
);

	job_t               mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	assign full    = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (FIFO_AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (FIFO_AW+1)'(1);
			end
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) empty |-> !pop)
		else $error("queue read while empty");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + (FIFO_AW+1)'(1)))
		else $error("fill count lost a write");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/jsu_back.sv =====
// Back end of the JSON string unescaper: walks each queued entry one result
// at a time into a registered output stage. Uses jsu_pkg.
`default_nettype none

module jsu_back import jsu_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire job_t         head,
	input  wire logic         empty,
	output logic              pop,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [15:0]       m_axis_tdata,  // [7:0] out_byte, [10:8] error_code, rest zero
	output logic [1:0]        m_axis_tuser,  // [1:0] result_kind
	output logic              m_axis_tlast   // last
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic [1:0] kind_q;
	logic [2:0] code_q;
	logic       last_q;
	logic       advance;
	logic       at_last;

	assign advance = !empty && (!valid_q || m_axis_tready);
	assign at_last = (idx_q == head.last_idx);
	assign pop     = advance && at_last;

	// Output valid and position within the current entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (advance) begin
				valid_q <= 1'b1;
				idx_q   <= at_last ? 2'd0 : idx_q + 2'd1;
			end else if (m_axis_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (advance) begin
			byte_q <= head.bytes[idx_q];
			kind_q <= head.kind;
			code_q <= head.code;
			last_q <= at_last;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {5'd0, code_q, byte_q};
	assign m_axis_tuser  = kind_q;
	assign m_axis_tlast  = last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/json_string_unescape_utf8.sv =====
// JSON string unescaper with UTF-8 output, top level; joins jsu_front,
// jsu_fifo and jsu_back, all built on jsu_pkg.
// Each result of a byte passes through the queue and then the registered output stage.
// Throughput: one input byte per cycle while the queue has room; one result per cycle
// when the sink is ready, so multi-byte results drain from the four-entry queue.
// Reset: arst_n clears the parser to waiting for an opening quote and empties the queue.
`default_nettype none

module json_string_unescape_utf8 import jsu_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  wire logic        s_axis_tuser,   // [0] input_ended
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,   // [7:0] out_byte, [10:8] error_code, rest zero
	output logic [1:0]       m_axis_tuser,   // [1:0] result_kind
	output logic             m_axis_tlast    // last
);

	logic fire;
	logic push;
	logic pop;
	logic full;
	logic empty;
	job_t job_in;
	job_t job_head;

	// Take a byte whenever the queue has room for its entry.
	assign s_axis_tready = !full;
	assign fire          = s_axis_tvalid && s_axis_tready;

	jsu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.in_byte  (s_axis_tdata),
		.in_ended (s_axis_tuser),
		.push     (push),
		.job      (job_in)
	);

	jsu_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (job_in),
		.pop     (pop),
		.rd_data (job_head),
		.full    (full),
		.empty   (empty)
	);

	jsu_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (job_head),
		.empty         (empty),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

`default_nettype wire
